// ===== hw/rtl/set_assoc_cache_lfu_lookup_core_defines.svh =====
// Assertion macros shared by the cache lookup checker.
`ifndef SET_ASSOC_CACHE_LFU_LOOKUP_CORE_DEFINES_SVH
`define SET_ASSOC_CACHE_LFU_LOOKUP_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clk_i and quiet while rst_ni is low.
`define SALFU_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("cache lookup check failed");

// Next-cycle implication, sampled on clk_i and quiet while rst_ni is low.
`define SALFU_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("cache lookup check failed");

`endif

// ===== hw/rtl/salfu_pkg.sv =====
// Shared constants and types of the LFU cache lookup core.
`default_nettype none
package salfu_pkg;

  localparam int unsigned MAX_SETS    = 256;
  localparam int unsigned MAX_WAYS    = 8;
  localparam int unsigned ADDR_WIDTH  = 32;
  localparam int unsigned COUNT_WIDTH = 32;

  localparam int unsigned SET_W  = $clog2(MAX_SETS);
  localparam int unsigned WAY_W  = $clog2(MAX_WAYS);
  localparam int unsigned NW_W   = $clog2(MAX_WAYS + 1);
  localparam int unsigned LINE_W = SET_W + WAY_W;
  localparam int unsigned LINES  = MAX_SETS * MAX_WAYS;
  localparam int unsigned CFG_W  = 4;
  localparam int unsigned SHAMT_W = CFG_W + 1;

  localparam logic [CFG_W-1:0] MAX_OFFSET_BITS = CFG_W'(12);
  localparam logic [CFG_W-1:0] MAX_SET_BITS    = CFG_W'(SET_W);

  localparam logic [CFG_W-1:0] RST_OFFSET_BITS = CFG_W'(4);
  localparam logic [CFG_W-1:0] RST_SET_BITS    = CFG_W'(8);
  localparam logic [CFG_W-1:0] RST_WAYS        = CFG_W'(8);

  typedef struct packed {
    logic [ADDR_WIDTH-1:0]  tag;
    logic [COUNT_WIDTH-1:0] count;
  } line_t;

endpackage
`default_nettype wire

// ===== hw/rtl/set_assoc_cache_lfu_lookup_core.sv =====
// Top level of the set-associative cache lookup core with LFU replacement.
//
// A transaction starts at a rising edge where start is high and busy is low; the
// byte address is split into offset, set index and tag using the current
// configuration. The core then steps through the ways in use of that set, one
// way per cycle, with a single tag comparator and a single count comparator
// fed from the line memory's one read port. The result (hit flag, set and way)
// appears on hit_o, set_index_o and way_o for exactly one cycle, marked by
// done_o, and cannot be held off by the receiver. After the accepting edge the
// core passes through a fetch state, the scan of the ways and a write-back
// state before done_o is raised; a miss scans every way in use, while a hit
// stops the scan at the matching way. The number of ways in use is 1 to 8.
// busy is already low while done_o is shown, so the next transaction may
// start in that same cycle.
// Valid bits and use counts read as zero after reset: a per-set flag marks the
// sets written since reset, so no clearing pass is needed and the core is
// ready as soon as reset is released. Configuration writes are meant to be
// issued only while busy is low.
`default_nettype none
module set_assoc_cache_lfu_lookup_core (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 cfg_we_i,
  input  wire logic [1:0]                           cfg_idx_i,
  input  wire logic [salfu_pkg::CFG_W-1:0]          cfg_data_i,
  input  wire logic                                 start,
  output logic                                      busy,
  input  wire logic [salfu_pkg::ADDR_WIDTH-1:0]     address_i,
  output logic                                      done_o,
  output logic                                      hit_o,
  output logic      [salfu_pkg::SET_W-1:0]          set_index_o,
  output logic      [salfu_pkg::WAY_W-1:0]          way_o
);

  localparam logic [1:0] CFG_OFFSET_BITS = 2'd0;
  localparam logic [1:0] CFG_SET_BITS    = 2'd1;
  localparam logic [1:0] CFG_WAYS        = 2'd2;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_FETCH = 2'd1;
  localparam logic [1:0] ST_SCAN  = 2'd2;
  localparam logic [1:0] ST_WRITE = 2'd3;

  // Configuration registers, kept raw; clamping happens where they are used.
  logic [salfu_pkg::CFG_W-1:0] cfg_ob_q, cfg_sb_q, cfg_ways_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_ob_q   <= salfu_pkg::RST_OFFSET_BITS;
      cfg_sb_q   <= salfu_pkg::RST_SET_BITS;
      cfg_ways_q <= salfu_pkg::RST_WAYS;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_OFFSET_BITS: cfg_ob_q   <= cfg_data_i;
        CFG_SET_BITS:    cfg_sb_q   <= cfg_data_i;
        CFG_WAYS:        cfg_ways_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Address split for the incoming transaction.
  logic [salfu_pkg::CFG_W-1:0]      ob_eff, sb_eff;
  logic [salfu_pkg::NW_W-1:0]       nw_eff;
  logic [salfu_pkg::SHAMT_W-1:0]    tag_shamt;
  logic [salfu_pkg::SET_W:0]        set_mask_wide;
  logic [salfu_pkg::ADDR_WIDTH-1:0] addr_shifted;
  logic [salfu_pkg::SET_W-1:0]      set_in;
  logic [salfu_pkg::ADDR_WIDTH-1:0] tag_in;

  always_comb begin
    ob_eff = (cfg_ob_q > salfu_pkg::MAX_OFFSET_BITS) ? salfu_pkg::MAX_OFFSET_BITS : cfg_ob_q;
    sb_eff = (cfg_sb_q > salfu_pkg::MAX_SET_BITS) ? salfu_pkg::MAX_SET_BITS : cfg_sb_q;
    if (cfg_ways_q == '0) begin
      nw_eff = salfu_pkg::NW_W'(1);
    end else if (cfg_ways_q > salfu_pkg::CFG_W'(salfu_pkg::MAX_WAYS)) begin
      nw_eff = salfu_pkg::NW_W'(salfu_pkg::MAX_WAYS);
    end else begin
      nw_eff = salfu_pkg::NW_W'(cfg_ways_q);
    end
    tag_shamt     = {1'b0, ob_eff} + {1'b0, sb_eff};
    set_mask_wide = ((salfu_pkg::SET_W + 1)'(1) << sb_eff) - (salfu_pkg::SET_W + 1)'(1);
    addr_shifted  = address_i >> ob_eff;
    set_in        = addr_shifted[salfu_pkg::SET_W-1:0] & set_mask_wide[salfu_pkg::SET_W-1:0];
    tag_in        = address_i >> tag_shamt;
  end

  // Sequencer and scan registers.
  logic [1:0]                        state_q, state_d;
  logic [salfu_pkg::SET_W-1:0]       set_q;
  logic [salfu_pkg::ADDR_WIDTH-1:0]  tag_q;
  logic [salfu_pkg::NW_W-1:0]        nw_q;
  logic [salfu_pkg::WAY_W-1:0]       way_q;
  logic                              hit_q, free_q;
  logic [salfu_pkg::WAY_W-1:0]       hit_way_q, free_way_q, min_way_q;
  logic [salfu_pkg::COUNT_WIDTH-1:0] hit_cnt_q, min_q;
  logic [salfu_pkg::MAX_SETS-1:0]    row_init_q;
  logic                              done_q, res_hit_q;
  logic [salfu_pkg::SET_W-1:0]       res_set_q;
  logic [salfu_pkg::WAY_W-1:0]       res_way_q;

  // Memories: one line word per (set, way) and one valid row per set.
  logic                              line_we, vrow_we;
  logic [salfu_pkg::WAY_W-1:0]       rd_way;
  logic [salfu_pkg::LINE_W-1:0]      line_raddr, line_waddr;
  salfu_pkg::line_t                  line_rd, line_wr;
  logic [salfu_pkg::MAX_WAYS-1:0]    vrow_rd, vrow_eff, vrow_wr;

  salfu_ram #(
    .Depth(salfu_pkg::LINES),
    .Width($bits(salfu_pkg::line_t))
  ) u_line_ram (
    .clk_i   (clk_i),
    .we_i    (line_we),
    .waddr_i (line_waddr),
    .wdata_i (line_wr),
    .raddr_i (line_raddr),
    .rdata_o (line_rd)
  );

  salfu_ram #(
    .Depth(salfu_pkg::MAX_SETS),
    .Width(salfu_pkg::MAX_WAYS)
  ) u_valid_ram (
    .clk_i   (clk_i),
    .we_i    (vrow_we),
    .waddr_i (set_q),
    .wdata_i (vrow_wr),
    .raddr_i (set_q),
    .rdata_o (vrow_rd)
  );

  // Shared compare unit: looks at one way per cycle during the scan.
  // An invalid line has never been filled since reset, so its count is zero.
  logic                              cur_valid, cur_match, cur_last, cur_less;
  logic [salfu_pkg::COUNT_WIDTH-1:0] cur_cnt;

  always_comb begin
    vrow_eff  = row_init_q[set_q] ? vrow_rd : '0;
    cur_valid = vrow_eff[way_q];
    cur_cnt   = cur_valid ? line_rd.count : '0;
    cur_match = cur_valid && (line_rd.tag == tag_q);
    cur_less  = (way_q == '0) || (cur_cnt < min_q);
    cur_last  = ({1'b0, way_q} == (nw_q - salfu_pkg::NW_W'(1)));
  end

  // Way chosen for the write-back and its incremented count.
  logic [salfu_pkg::WAY_W-1:0]       pick;
  logic [salfu_pkg::COUNT_WIDTH-1:0] pick_cnt;
  logic [salfu_pkg::MAX_WAYS-1:0]    pick_onehot;

  always_comb begin
    if (hit_q) begin
      pick     = hit_way_q;
      pick_cnt = hit_cnt_q;
    end else if (free_q) begin
      pick     = free_way_q;
      pick_cnt = '0;
    end else begin
      pick     = min_way_q;
      pick_cnt = min_q;
    end
    pick_onehot   = salfu_pkg::MAX_WAYS'(1) << pick;
    line_wr.tag   = tag_q;
    line_wr.count = pick_cnt + salfu_pkg::COUNT_WIDTH'(1);
    vrow_wr       = vrow_eff | pick_onehot;
    line_we       = (state_q == ST_WRITE);
    vrow_we       = (state_q == ST_WRITE);
    line_waddr    = {set_q, pick};
    rd_way        = (state_q == ST_SCAN) ? way_q + salfu_pkg::WAY_W'(1) : '0;
    line_raddr    = {set_q, rd_way};
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (start) state_d = ST_FETCH;
      ST_FETCH: state_d = ST_SCAN;
      ST_SCAN:  if (cur_match || cur_last) state_d = ST_WRITE;
      ST_WRITE: state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      row_init_q <= '0;
      done_q     <= 1'b0;
      hit_q      <= 1'b0;
      free_q     <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= (state_q == ST_WRITE);
      if (state_q == ST_FETCH) begin
        hit_q  <= 1'b0;
        free_q <= 1'b0;
      end else if (state_q == ST_SCAN) begin
        if (cur_match) begin
          hit_q <= 1'b1;
        end else if (!cur_valid && !free_q) begin
          free_q <= 1'b1;
        end
      end
      if (state_q == ST_WRITE) begin
        row_init_q[set_q] <= 1'b1;
      end
    end
  end

  // Payload registers of the sequencer.
  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && start) begin
      set_q <= set_in;
      tag_q <= tag_in;
      nw_q  <= nw_eff;
    end
    if (state_q == ST_FETCH) begin
      way_q <= '0;
    end else if (state_q == ST_SCAN) begin
      way_q <= way_q + salfu_pkg::WAY_W'(1);
      if (cur_match) begin
        hit_way_q <= way_q;
        hit_cnt_q <= cur_cnt;
      end
      if (!cur_valid && !free_q) begin
        free_way_q <= way_q;
      end
      if (cur_less) begin
        min_q     <= cur_cnt;
        min_way_q <= way_q;
      end
    end
    if (state_q == ST_WRITE) begin
      res_hit_q <= hit_q;
      res_set_q <= set_q;
      res_way_q <= pick;
    end
  end

  assign busy        = (state_q != ST_IDLE);
  assign done_o      = done_q;
  assign hit_o       = res_hit_q;
  assign set_index_o = res_set_q;
  assign way_o       = res_way_q;

endmodule
`default_nettype wire

// ===== hw/rtl/salfu_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module salfu_ram #(
  parameter int unsigned Depth = 256,
  parameter int unsigned Width = 8
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

// ===== hw/rtl/salfu_checker.sv =====
// Port-level checker of the cache lookup core, bound to the top level.
`default_nettype none
`include "set_assoc_cache_lfu_lookup_core_defines.svh"
module salfu_checker (
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic start_i,
  input wire logic busy_i,
  input wire logic done_i
);

  // An accepted transaction makes the core busy right away.
  `SALFU_ASSERT_NEXT(a_accept_busy, start_i && !busy_i, busy_i)
  // A result is only shown once the core has finished with it.
  `SALFU_ASSERT_NOW(a_done_idle, done_i, !busy_i)
  // Every end of a busy period delivers exactly one result.
  `SALFU_ASSERT_NOW(a_end_done, $fell(busy_i), done_i)
  `SALFU_ASSERT_NEXT(a_done_pulse, done_i, !done_i)

endmodule

bind set_assoc_cache_lfu_lookup_core salfu_checker u_salfu_checker (
  .clk_i   (clk_i),
  .rst_ni  (rst_ni),
  .start_i (start),
  .busy_i  (busy),
  .done_i  (done_o)
);
`default_nettype wire
